// ===== src/tema_pkg.sv =====
// Shared types and constants for the tensor error metric accumulator.
package tema_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_LOG2 = 24;

  localparam int CNT_W = COUNT_LOG2 + 1;
  localparam int DOT_W = 2 * SAMPLE_W + COUNT_LOG2;
  localparam int SQ_W  = DOT_W - 1;
  localparam int DSQ_W = DOT_W + 2;
  localparam int ADF_W = SAMPLE_W + 1 + COUNT_LOG2;
  localparam int ARF_W = SAMPLE_W + COUNT_LOG2;
  localparam int PW    = 2 * SAMPLE_W + 2;

  localparam int MSE_W  = 35;
  localparam int COS_W  = 16;
  localparam int REL_W  = 32;
  localparam int ICNT_W = 25;

  localparam int COS_BITS = 16;
  localparam logic [COS_BITS-1:0] COS_MAX = 16'd32767;

  localparam int MUL_W  = DOT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SRCH_W = PROD_W + 2 * COS_BITS;
  localparam int MUL_CW = $clog2(MUL_W);
  localparam int K_W    = $clog2(COS_BITS);

  localparam int REL_SHIFT     = 16;
  localparam int REL_LIMIT_BIT = 47;
  localparam int DIV_NW = 64;
  localparam int DIV_VW = ARF_W;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef struct packed {
    logic signed [15:0] test_value;
    logic signed [15:0] ref_value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [MSE_W-1:0]        mse_value;
    logic signed [COS_W-1:0] cosine_value;
    logic [REL_W-1:0]        rel_abs_error;
    logic                    cosine_undefined;
    logic                    rel_undefined;
    logic [ICNT_W-1:0]       item_count;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [DOT_W-1:0] dot;
    logic [SQ_W-1:0]  tsq;
    logic [SQ_W-1:0]  rsq;
    logic [DSQ_W-1:0] dsq;
    logic [ADF_W-1:0] adf;
    logic [ARF_W-1:0] arf;
  } sums_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// ===== src/tema_front.sv =====
// Front end: takes sample pairs, forms products and accumulates the sums.
module tema_front import tema_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_push,
  output sums_t    q_data,
  input  logic     q_full
);

  logic signed [SAMPLE_W:0]   t_x, r_x;
  logic signed [SAMPLE_W+1:0] d_x;
  logic [SAMPLE_W:0]          ad, ar;
  logic                       go, adv, en;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             s1_v_r, s1_en_r, s1_last_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic signed [PW-1:0] s1_tr_r, s1_tt_r, s1_rr_r;
  logic [PW-1:0]    s1_dd_r;
  logic [SAMPLE_W:0] s1_ad_r, s1_ar_r;

  sums_t sum_r, sum_nxt, add;

  assign t_x = {in_data.test_value[SAMPLE_W-1], in_data.test_value[SAMPLE_W-1:0]};
  assign r_x = {in_data.ref_value[SAMPLE_W-1], in_data.ref_value[SAMPLE_W-1:0]};
  assign d_x = t_x - r_x;
  assign ad  = d_x[SAMPLE_W+1] ? (SAMPLE_W+1)'(0) - d_x[SAMPLE_W:0] : d_x[SAMPLE_W:0];
  assign ar  = r_x[SAMPLE_W] ? (SAMPLE_W+1)'(0) - r_x : r_x;

  // hold stage 1 while a closing beat waits for queue space
  assign in_stall = s1_v_r && s1_last_r && q_full;
  assign adv      = !in_stall;
  assign go       = in_valid && adv;
  assign en       = !cnt_r[COUNT_LOG2];

  always_comb begin
    cnt_nxt = cnt_r;
    if (go) begin
      cnt_nxt = in_data.last_item ? '0 : cnt_r + CNT_W'(en);
    end
  end

  always_comb begin
    add = '0;
    if (s1_en_r) begin
      add.dot = {{(DOT_W-PW){s1_tr_r[PW-1]}}, s1_tr_r};
      add.tsq = {{(SQ_W-PW){1'b0}}, s1_tt_r};
      add.rsq = {{(SQ_W-PW){1'b0}}, s1_rr_r};
      add.dsq = {{(DSQ_W-PW){1'b0}}, s1_dd_r};
      add.adf = {{(ADF_W-SAMPLE_W-1){1'b0}}, s1_ad_r};
      add.arf = {{(ARF_W-SAMPLE_W-1){1'b0}}, s1_ar_r};
    end
    sum_nxt       = sum_r;
    sum_nxt.count = s1_cnt_r;
    sum_nxt.dot   = sum_r.dot + add.dot;
    sum_nxt.tsq   = sum_r.tsq + add.tsq;
    sum_nxt.rsq   = sum_r.rsq + add.rsq;
    sum_nxt.dsq   = sum_r.dsq + add.dsq;
    sum_nxt.adf   = sum_r.adf + add.adf;
    sum_nxt.arf   = sum_r.arf + add.arf;
  end

  assign q_push = s1_v_r && s1_last_r && !q_full;
  assign q_data = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (adv) begin
        s1_v_r <= go;
        if (s1_v_r) begin
          sum_r <= s1_last_r ? '0 : sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_en_r   <= en;
      s1_last_r <= in_data.last_item;
      s1_cnt_r  <= cnt_r + CNT_W'(en);
      s1_tr_r   <= t_x * r_x;
      s1_tt_r   <= t_x * t_x;
      s1_rr_r   <= r_x * r_x;
      s1_dd_r   <= PW'(ad) * PW'(ad);
      s1_ad_r   <= ad;
      s1_ar_r   <= ar;
    end
  end

endmodule

// ===== src/tema_fifo.sv =====
// Two-entry queue of finished sum sets between front and back.
module tema_fifo import tema_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  q_ctl_t ctl_in,
  input  sums_t  wdata,
  input  logic   pop,
  output logic   empty,
  output q_ctl_t ctl_out,
  output sums_t  rdata
);

  sums_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;

  assign empty        = (n_r == 2'd0);
  assign ctl_out.full = (n_r == 2'd2);
  assign ctl_out.push = ctl_in.push;
  assign rdata        = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      if (ctl_in.push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      n_r <= n_r + 2'(ctl_in.push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== src/tema_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tema_div import tema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_VW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_VW-1:0] rem_r, den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_VW:0]   sh;
  logic              ge;

  assign sh   = {rem_r, quo_r[DIV_NW-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_VW'(sh - {1'b0, den_r}) : sh[DIV_VW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
      cnt_r <= cnt_r + DIV_CW'(1);
    end
  end

endmodule

// ===== src/tema_back.sv =====
// Back end: products, cosine search and divisions for one finished tensor.
module tema_back import tema_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  sums_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULP = 7'b0000010,
    S_MULL = 7'b0000100,
    S_SRCH = 7'b0001000,
    S_DIVM = 7'b0010000,
    S_DIVR = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  st_t st_r;
  sums_t e_r;

  logic [PROD_W-1:0] mc_r, acc_r, acc_nxt, p_r;
  logic [MUL_W-1:0]  mp_r, mag;
  logic [MUL_CW-1:0] mcnt_r;
  logic [SRCH_W-1:0] l_r, s_r, x_r, pk_r, trial;
  logic [COS_BITS-1:0] c_r;
  logic [K_W-1:0]    k_r;
  logic [MSE_W-1:0]  mse_r;
  logic              take, neg, mul_end;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo, adf_x;
  logic [DIV_VW-1:0] div_den;

  logic              cos_undef, rel_undef;
  logic [COS_W-1:0]  cos_v;
  logic [REL_W-1:0]  rel_v;
  out_item_t         out_r;
  logic              ov_r;

  assign neg     = e_r.dot[DOT_W-1];
  assign mag     = neg ? MUL_W'(0) - e_r.dot : e_r.dot;
  assign acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
  assign mul_end = (mcnt_r == MUL_CW'(MUL_W - 1));
  assign trial   = s_r + x_r + pk_r;
  assign take    = (trial <= l_r);
  assign q_pop   = (st_r == S_IDLE) && !q_empty;
  assign adf_x   = DIV_NW'(e_r.adf);

  assign div_start = ((st_r == S_SRCH) && (k_r == '0)) || ((st_r == S_DIVM) && div_done);
  assign div_num   = (st_r == S_SRCH) ? DIV_NW'(e_r.dsq) : DIV_NW'(adf_x << REL_SHIFT);
  assign div_den   = (st_r == S_SRCH) ? DIV_VW'(e_r.count) : DIV_VW'(e_r.arf);

  tema_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cos_undef = (e_r.tsq == '0) || (e_r.rsq == '0);
  assign rel_undef = (e_r.arf == '0);

  always_comb begin
    if (cos_undef) begin
      cos_v = '0;
    end else if (neg) begin
      cos_v = COS_W'(0) - COS_W'(c_r);
    end else begin
      cos_v = (c_r > COS_MAX) ? COS_W'(COS_MAX) : COS_W'(c_r);
    end
    if (rel_undef) begin
      rel_v = '0;
    end else if ((adf_x >> REL_LIMIT_BIT) != '0 || div_quo[DIV_NW-1:REL_W] != '0) begin
      rel_v = '1;
    end else begin
      rel_v = div_quo[REL_W-1:0];
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (!q_empty) st_r <= S_MULP;
        S_MULP: if (mul_end) st_r <= S_MULL;
        S_MULL: if (mul_end) st_r <= S_SRCH;
        S_SRCH: if (k_r == '0) st_r <= S_DIVM;
        S_DIVM: if (div_done) st_r <= S_DIVR;
        S_DIVR: begin
          if (div_done) begin
            st_r <= S_OUT;
            ov_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            st_r <= S_IDLE;
            ov_r <= 1'b0;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        e_r    <= q_data;
        mc_r   <= PROD_W'(q_data.tsq);
        mp_r   <= MUL_W'(q_data.rsq);
        acc_r  <= '0;
        mcnt_r <= '0;
      end
      S_MULP: begin
        acc_r  <= acc_nxt;
        mc_r   <= mc_r << 1;
        mp_r   <= mp_r >> 1;
        mcnt_r <= mcnt_r + MUL_CW'(1);
        if (mul_end) begin
          p_r    <= acc_nxt;
          mc_r   <= PROD_W'(mag);
          mp_r   <= mag;
          acc_r  <= '0;
          mcnt_r <= '0;
        end
      end
      S_MULL: begin
        acc_r  <= acc_nxt;
        mc_r   <= mc_r << 1;
        mp_r   <= mp_r >> 1;
        mcnt_r <= mcnt_r + MUL_CW'(1);
        if (mul_end) begin
          l_r  <= SRCH_W'({acc_nxt, {(2*COS_BITS-2){1'b0}}});
          pk_r <= SRCH_W'({p_r, {(2*COS_BITS-2){1'b0}}});
          s_r  <= '0;
          x_r  <= '0;
          c_r  <= '0;
          k_r  <= K_W'(COS_BITS - 1);
        end
      end
      S_SRCH: begin
        // keep x = c*P << (k+1) and pk = P << 2k as k walks down
        if (take) begin
          s_r <= trial;
          x_r <= (x_r + (pk_r << 1)) >> 1;
          c_r <= c_r | (COS_BITS'(1) << k_r);
        end else begin
          x_r <= x_r >> 1;
        end
        pk_r <= pk_r >> 2;
        k_r  <= k_r - K_W'(1);
      end
      S_DIVM: begin
        if (div_done) mse_r <= (e_r.count == '0) ? '0 : div_quo[MSE_W-1:0];
      end
      S_DIVR: begin
        if (div_done) begin
          out_r.mse_value        <= mse_r;
          out_r.cosine_value     <= cos_v;
          out_r.rel_abs_error    <= rel_v;
          out_r.cosine_undefined <= cos_undef;
          out_r.rel_undefined    <= rel_undef;
          out_r.item_count       <= ICNT_W'(e_r.count);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/tensor_error_metric_accumulator_unit.sv =====
// Top level of the tensor error metric accumulator.
//
// Input channel (in_valid / in_stall / in_data): one test/reference sample
// pair per beat, with a last flag closing the tensor. A beat is taken every
// cycle while in_stall is low; the sums update from the stage-1 registers.
// Result channel (out_valid / out_stall / out_data): one result per tensor,
// carrying MSE, cosine similarity, relative absolute error, the two
// undefined flags and the pair count.
// A closing beat hands its sums to a two-entry queue. The back end forms
// the two shift-add products, then runs the cosine bit search and the two
// restoring divisions on the shared one-bit-per-cycle divider and
// multiplier; it takes one tensor at a time from the queue.
// The front keeps taking beats meanwhile; it stalls only when a closing
// beat finds the queue full.
// A stalled result holds in the output register; the back end waits.
// Synchronous reset clears the sums, counter, queue and back-end state.
module tensor_error_metric_accumulator_unit import tema_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  q_ctl_t q_in, q_out;
  sums_t  q_wdata, q_rdata;
  logic   q_pop, q_empty;

  tema_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_in.push),
    .q_data   (q_wdata),
    .q_full   (q_out.full)
  );

  assign q_in.full = q_out.full;

  tema_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (q_in),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .empty   (q_empty),
    .ctl_out (q_out),
    .rdata   (q_rdata)
  );

  tema_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/tema_checker.sv =====
// Port-level checks for the accumulator top level, with its bind.
module tema_checker import tema_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.item_count != '0)
    else $error("result with zero pair count");

  a_cos_undef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cosine_undefined |-> out_data.cosine_value == '0)
    else $error("undefined cosine not zero");

  a_rel_undef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rel_undefined |-> out_data.rel_abs_error == '0)
    else $error("undefined relative error not zero");

endmodule

bind tensor_error_metric_accumulator_unit tema_checker u_checker (.*);
